>>> rtl/pidfd_pkg.sv
// shared types, constants and saturation helpers for the filtered-derivative pid block
// no dependencies
`default_nettype none

package pidfd_pkg;

   localparam int DataW    = 32;
   localparam int AccW     = 48;
   localparam int FracW    = 16;
   localparam int DtW      = 16;
   localparam int AlphaW   = 17;
   localparam int ErrW     = 33;
   localparam int DiffW    = 34;
   localparam int MulAW    = 48;
   localparam int MulBW    = 33;
   localparam int ProdW    = MulAW + MulBW;
   localparam int DivNW    = 50;
   localparam int DivDW    = 32;
   localparam int WideW    = 50;
   localparam int CntW     = 6;
   localparam int CsrIdxW  = 3;
   localparam int MulSteps = MulBW;
   localparam int DivSteps = DivNW;

   localparam logic [AlphaW-1:0]        AlphaOne    = 17'h10000;
   localparam logic [AlphaW-1:0]        AlphaRst    = 17'd39322;
   localparam logic signed [DataW-1:0]  DriveMinRst = -32'sd16711680;
   localparam logic signed [DataW-1:0]  DriveMaxRst = 32'sd16711680;
   localparam logic [DivDW-1:0]         UnitDen     = 32'h0001_0000;
   localparam logic signed [AccW-1:0]   AccMax      = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [AccW-1:0]   AccMin      = 48'sh8000_0000_0000;
   localparam logic signed [AccW-1:0]   NoKiLimit   = 48'sd65536000000;
   localparam logic signed [WideW-1:0]  AccMaxW     = 50'sd140737488355327;
   localparam logic signed [WideW-1:0]  AccMinW     = -50'sd140737488355328;
   localparam logic [64:0]              MagPosMax   = 65'h7FFF_FFFF_FFFF;
   localparam logic [64:0]              MagNegMax   = 65'h8000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_MUL,
      ST_INC_MUL,
      ST_LIM_DIV,
      ST_I_MUL,
      ST_DER_DIV,
      ST_T1_MUL,
      ST_T2_MUL,
      ST_D_MUL,
      ST_DONE
   } state_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_GAIN_PROP,
      CSR_GAIN_INTEG,
      CSR_GAIN_DERIV,
      CSR_DRIVE_MIN,
      CSR_DRIVE_MAX,
      CSR_DERIV_ALPHA
   } csr_index_type;

   typedef enum logic {
      OP_COMPUTE,
      OP_CLEAR
   } opcode_type;

   typedef struct packed {
      logic load;
      logic step;
   } unit_ctl_type;

   function automatic logic [WideW-1:0] mag_w(input logic signed [WideW-1:0] x);
      logic [WideW-1:0] r;
      r = x[WideW-1] ? WideW'(-x) : WideW'(x);
      return r;
   endfunction

   function automatic logic signed [AccW-1:0] from_mag(input logic neg, input logic [64:0] m);
      logic signed [AccW-1:0] r;
      if (neg) begin
         if (m > MagNegMax) r = AccMin;
         else r = -$signed(m[AccW-1:0]);
      end else begin
         if (m > MagPosMax) r = AccMax;
         else r = $signed(m[AccW-1:0]);
      end
      return r;
   endfunction

   function automatic logic signed [AccW-1:0] prod_shift(input logic neg,
                                                         input logic [ProdW-1:0] p);
      logic signed [AccW-1:0] r;
      r = from_mag(neg, p[ProdW-1:FracW]);
      return r;
   endfunction

   function automatic logic signed [AccW-1:0] sat_acc(input logic signed [WideW-1:0] x);
      logic signed [AccW-1:0] r;
      if (x > AccMaxW) r = AccMax;
      else if (x < AccMinW) r = AccMin;
      else r = x[AccW-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pid_filtered_derivative_antiwindup_top.sv
// a compute transfer runs six serial multiplies and two serial divides one after another on
// shared units; a clear or zero step_time transfer skips them and goes straight to the done state
// a new request is taken only while idle; req_stall is high until the result is handed to the
// response register, which waits while rsp_stall holds a previous response
// reset: synchronous, clears integrator and filter history and loads register defaults
// depends on pidfd_pkg, pidfd_mul, pidfd_div
`default_nettype none

module pid_filtered_derivative_antiwindup_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic signed [pidfd_pkg::DataW-1:0]  req_target,
   input  wire logic signed [pidfd_pkg::DataW-1:0]  req_measured,
   input  wire logic [pidfd_pkg::DtW-1:0]           req_step_time,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pidfd_pkg::DataW-1:0]       rsp_drive,
   input  wire logic                                csr_wr_en,
   input  wire logic [pidfd_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [pidfd_pkg::DataW-1:0]         csr_wdata
);

   localparam int W  = pidfd_pkg::WideW;
   localparam int AW = pidfd_pkg::AccW;
   localparam int DW = pidfd_pkg::DataW;

   pidfd_pkg::state_type state_ff, state_in;
   logic [pidfd_pkg::CntW-1:0] cnt_ff, cnt_in;

   logic signed [DW-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic signed [DW-1:0] dmin_ff, dmin_in, dmax_ff, dmax_in;
   logic [pidfd_pkg::AlphaW-1:0] alpha_ff, alpha_in;

   logic signed [AW-1:0] integ_ff, integ_in, smooth_ff, smooth_in;
   logic signed [pidfd_pkg::ErrW-1:0] last_err_ff, last_err_in, err_ff, err_in;
   logic [pidfd_pkg::DtW-1:0] dt_ff, dt_in;
   logic signed [AW-1:0] p_ff, p_in, i_ff, i_in, tmp_ff, tmp_in;
   logic signed [DW-1:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_drive_ff, rsp_drive_in;

   pidfd_pkg::unit_ctl_type mul_ctl, div_ctl;
   logic [pidfd_pkg::MulAW-1:0] mul_a;
   logic [pidfd_pkg::MulBW-1:0] mul_b;
   logic mul_neg;
   logic [pidfd_pkg::ProdW-1:0] prod;
   logic [pidfd_pkg::DivNW-1:0] div_num, quot;
   logic [pidfd_pkg::DivDW-1:0] div_den;

   logic accept, out_free, is_mul, is_div, at_last;
   logic [W-1:0] kp_mag, ki_mag, kd_mag, dmax_mag, err_mag, integ_mag, smooth_mag;
   logic [W-1:0] tmp_mag, diff_mag;
   logic signed [pidfd_pkg::DiffW-1:0] diff;
   logic [pidfd_pkg::AlphaW-1:0] alpha_c;
   logic signed [AW-1:0] mres, limit;
   logic signed [W-1:0] drv_sum, drv_hi;

   pidfd_mul u_mul (
      .clock (clock),
      .ctl   (mul_ctl),
      .a_mag (mul_a),
      .b_mag (mul_b),
      .prod  (prod)
   );

   pidfd_div u_div (
      .clock (clock),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot)
   );

   assign accept   = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign is_mul   = (state_ff == pidfd_pkg::ST_P_MUL) || (state_ff == pidfd_pkg::ST_INC_MUL) ||
                     (state_ff == pidfd_pkg::ST_I_MUL) || (state_ff == pidfd_pkg::ST_T1_MUL) ||
                     (state_ff == pidfd_pkg::ST_T2_MUL) || (state_ff == pidfd_pkg::ST_D_MUL);
   assign is_div   = (state_ff == pidfd_pkg::ST_LIM_DIV) || (state_ff == pidfd_pkg::ST_DER_DIV);
   assign at_last  = is_mul ? (cnt_ff == pidfd_pkg::CntW'(pidfd_pkg::MulSteps + 1))
                            : (cnt_ff == pidfd_pkg::CntW'(pidfd_pkg::DivSteps + 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidfd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == pidfd_pkg::OP_CLEAR || req_step_time == '0)
                  state_in = pidfd_pkg::ST_DONE;
               else
                  state_in = pidfd_pkg::ST_P_MUL;
            end
         end
         pidfd_pkg::ST_P_MUL:   if (at_last) state_in = pidfd_pkg::ST_INC_MUL;
         pidfd_pkg::ST_INC_MUL: if (at_last) state_in = pidfd_pkg::ST_LIM_DIV;
         pidfd_pkg::ST_LIM_DIV: if (at_last) state_in = pidfd_pkg::ST_I_MUL;
         pidfd_pkg::ST_I_MUL:   if (at_last) state_in = pidfd_pkg::ST_DER_DIV;
         pidfd_pkg::ST_DER_DIV: if (at_last) state_in = pidfd_pkg::ST_T1_MUL;
         pidfd_pkg::ST_T1_MUL:  if (at_last) state_in = pidfd_pkg::ST_T2_MUL;
         pidfd_pkg::ST_T2_MUL:  if (at_last) state_in = pidfd_pkg::ST_D_MUL;
         pidfd_pkg::ST_D_MUL:   if (at_last) state_in = pidfd_pkg::ST_DONE;
         pidfd_pkg::ST_DONE:    if (out_free) state_in = pidfd_pkg::ST_IDLE;
         default:               state_in = pidfd_pkg::ST_IDLE;
      endcase
      cnt_in = (state_in != state_ff || !(is_mul || is_div)) ? '0 : cnt_ff + 1'b1;
   end

   // unit control
   always_comb begin
      req_stall    = 1'b1;
      mul_ctl.load = 1'b0;
      mul_ctl.step = 1'b0;
      div_ctl.load = 1'b0;
      div_ctl.step = 1'b0;
      unique case (state_ff)
         pidfd_pkg::ST_IDLE: req_stall = 1'b0;
         pidfd_pkg::ST_P_MUL, pidfd_pkg::ST_INC_MUL, pidfd_pkg::ST_I_MUL,
         pidfd_pkg::ST_T1_MUL, pidfd_pkg::ST_T2_MUL, pidfd_pkg::ST_D_MUL: begin
            mul_ctl.load = (cnt_ff == '0);
            mul_ctl.step = (cnt_ff != '0) && (cnt_ff <= pidfd_pkg::CntW'(pidfd_pkg::MulSteps));
         end
         pidfd_pkg::ST_LIM_DIV, pidfd_pkg::ST_DER_DIV: begin
            div_ctl.load = (cnt_ff == '0);
            div_ctl.step = (cnt_ff != '0) && (cnt_ff <= pidfd_pkg::CntW'(pidfd_pkg::DivSteps));
         end
         pidfd_pkg::ST_DONE: req_stall = 1'b1;
         default:            req_stall = 1'b1;
      endcase
   end

   // register writes
   always_comb begin
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      kd_in    = kd_ff;
      dmin_in  = dmin_ff;
      dmax_in  = dmax_ff;
      alpha_in = alpha_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pidfd_pkg::CSR_GAIN_PROP:   kp_in    = $signed(csr_wdata);
            pidfd_pkg::CSR_GAIN_INTEG:  ki_in    = $signed(csr_wdata);
            pidfd_pkg::CSR_GAIN_DERIV:  kd_in    = $signed(csr_wdata);
            pidfd_pkg::CSR_DRIVE_MIN:   dmin_in  = $signed(csr_wdata);
            pidfd_pkg::CSR_DRIVE_MAX:   dmax_in  = $signed(csr_wdata);
            pidfd_pkg::CSR_DERIV_ALPHA: alpha_in = csr_wdata[pidfd_pkg::AlphaW-1:0];
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      kp_mag     = pidfd_pkg::mag_w({{(W-DW){kp_ff[DW-1]}}, kp_ff});
      ki_mag     = pidfd_pkg::mag_w({{(W-DW){ki_ff[DW-1]}}, ki_ff});
      kd_mag     = pidfd_pkg::mag_w({{(W-DW){kd_ff[DW-1]}}, kd_ff});
      dmax_mag   = pidfd_pkg::mag_w({{(W-DW){dmax_ff[DW-1]}}, dmax_ff});
      err_mag    = pidfd_pkg::mag_w({{(W-pidfd_pkg::ErrW){err_ff[pidfd_pkg::ErrW-1]}}, err_ff});
      integ_mag  = pidfd_pkg::mag_w({{(W-AW){integ_ff[AW-1]}}, integ_ff});
      smooth_mag = pidfd_pkg::mag_w({{(W-AW){smooth_ff[AW-1]}}, smooth_ff});
      tmp_mag    = pidfd_pkg::mag_w({{(W-AW){tmp_ff[AW-1]}}, tmp_ff});
      diff       = {err_ff[pidfd_pkg::ErrW-1], err_ff}
                 - {last_err_ff[pidfd_pkg::ErrW-1], last_err_ff};
      diff_mag   = pidfd_pkg::mag_w({{(W-pidfd_pkg::DiffW){diff[pidfd_pkg::DiffW-1]}}, diff});
      alpha_c    = (alpha_ff > pidfd_pkg::AlphaOne) ? pidfd_pkg::AlphaOne : alpha_ff;

      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      div_num = '0;
      div_den = pidfd_pkg::UnitDen;
      mres    = '0;
      limit   = '0;
      drv_sum = '0;
      drv_hi  = '0;

      integ_in    = integ_ff;
      smooth_in   = smooth_ff;
      last_err_in = last_err_ff;
      err_in      = err_ff;
      dt_in       = dt_ff;
      p_in        = p_ff;
      i_in        = i_ff;
      tmp_in      = tmp_ff;
      res_in      = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_drive_in = rsp_drive_ff;

      case (state_ff)
         pidfd_pkg::ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (req_opcode == pidfd_pkg::OP_CLEAR) begin
                  integ_in    = '0;
                  last_err_in = '0;
                  smooth_in   = '0;
               end
               err_in = {req_target[DW-1], req_target} - {req_measured[DW-1], req_measured};
               dt_in  = req_step_time;
            end
         end
         pidfd_pkg::ST_P_MUL: begin
            mul_a   = kp_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = err_mag[pidfd_pkg::MulBW-1:0];
            mul_neg = kp_ff[DW-1] ^ err_ff[pidfd_pkg::ErrW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            if (at_last) p_in = mres;
         end
         pidfd_pkg::ST_INC_MUL: begin
            mul_a   = err_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = pidfd_pkg::MulBW'(dt_ff);
            mul_neg = err_ff[pidfd_pkg::ErrW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            if (at_last)
               integ_in = pidfd_pkg::sat_acc({{(W-AW){integ_ff[AW-1]}}, integ_ff}
                                           + {{(W-AW){mres[AW-1]}}, mres});
         end
         pidfd_pkg::ST_LIM_DIV: begin
            div_num = {dmax_mag[pidfd_pkg::DivNW-pidfd_pkg::FracW-1:0],
                       {pidfd_pkg::FracW{1'b0}}};
            div_den = (!ki_ff[DW-1] && ki_ff != '0) ? ki_ff : pidfd_pkg::UnitDen;
            if (ki_ff == '0)
               limit = pidfd_pkg::NoKiLimit;
            else if (quot > {2'b00, pidfd_pkg::AccMax})
               limit = pidfd_pkg::AccMax;
            else
               limit = $signed(quot[AW-1:0]);
            if (at_last) begin
               if (integ_ff > limit) integ_in = limit;
               else if (integ_ff < -limit) integ_in = -limit;
            end
         end
         pidfd_pkg::ST_I_MUL: begin
            mul_a   = integ_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = ki_mag[pidfd_pkg::MulBW-1:0];
            mul_neg = ki_ff[DW-1] ^ integ_ff[AW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            if (at_last) i_in = mres;
         end
         pidfd_pkg::ST_DER_DIV: begin
            div_num = {diff_mag[pidfd_pkg::DiffW-1:0], {pidfd_pkg::FracW{1'b0}}};
            div_den = pidfd_pkg::DivDW'(dt_ff);
            if (at_last)
               tmp_in = pidfd_pkg::from_mag(diff[pidfd_pkg::DiffW-1], 65'(quot));
         end
         pidfd_pkg::ST_T1_MUL: begin
            mul_a   = tmp_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = pidfd_pkg::MulBW'(alpha_c);
            mul_neg = tmp_ff[AW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            if (at_last) tmp_in = mres;
         end
         pidfd_pkg::ST_T2_MUL: begin
            mul_a   = smooth_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = pidfd_pkg::MulBW'(pidfd_pkg::AlphaOne - alpha_c);
            mul_neg = smooth_ff[AW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            if (at_last)
               smooth_in = pidfd_pkg::sat_acc({{(W-AW){tmp_ff[AW-1]}}, tmp_ff}
                                            + {{(W-AW){mres[AW-1]}}, mres});
         end
         pidfd_pkg::ST_D_MUL: begin
            mul_a   = smooth_mag[pidfd_pkg::MulAW-1:0];
            mul_b   = kd_mag[pidfd_pkg::MulBW-1:0];
            mul_neg = kd_ff[DW-1] ^ smooth_ff[AW-1];
            mres    = pidfd_pkg::prod_shift(mul_neg, prod);
            drv_sum = {{(W-AW){p_ff[AW-1]}}, p_ff} + {{(W-AW){i_ff[AW-1]}}, i_ff}
                    + {{(W-AW){mres[AW-1]}}, mres};
            drv_hi  = drv_sum;
            if (drv_sum > $signed({{(W-DW){dmax_ff[DW-1]}}, dmax_ff}))
               drv_hi = {{(W-DW){dmax_ff[DW-1]}}, dmax_ff};
            if (drv_hi < $signed({{(W-DW){dmin_ff[DW-1]}}, dmin_ff}))
               drv_hi = {{(W-DW){dmin_ff[DW-1]}}, dmin_ff};
            if (at_last) begin
               res_in      = drv_hi[DW-1:0];
               last_err_in = err_ff;
            end
         end
         pidfd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidfd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         dmin_ff      <= pidfd_pkg::DriveMinRst;
         dmax_ff      <= pidfd_pkg::DriveMaxRst;
         alpha_ff     <= pidfd_pkg::AlphaRst;
         integ_ff     <= '0;
         smooth_ff    <= '0;
         last_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         dmin_ff      <= dmin_in;
         dmax_ff      <= dmax_in;
         alpha_ff     <= alpha_in;
         integ_ff     <= integ_in;
         smooth_ff    <= smooth_in;
         last_err_ff  <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      tmp_ff       <= tmp_in;
      res_ff       <= res_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

`default_nettype wire

>>> rtl/pidfd_mul.sv
// bit-serial shift-add magnitude multiplier, one multiplier bit per cycle while step is high
// depends on pidfd_pkg
`default_nettype none

module pidfd_mul (
   input  wire logic                            clock,
   input  wire pidfd_pkg::unit_ctl_type         ctl,
   input  wire logic [pidfd_pkg::MulAW-1:0]     a_mag,
   input  wire logic [pidfd_pkg::MulBW-1:0]     b_mag,
   output logic [pidfd_pkg::ProdW-1:0]          prod
);

   logic [pidfd_pkg::MulAW-1:0] a_ff, a_in;
   logic [pidfd_pkg::MulAW-1:0] hi_ff, hi_in;
   logic [pidfd_pkg::MulBW-1:0] lo_ff, lo_in;
   logic [pidfd_pkg::MulAW:0]   sum;

   always_comb begin
      sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in  = a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctl.load) begin
         a_in  = a_mag;
         hi_in = '0;
         lo_in = b_mag;
      end else if (ctl.step) begin
         hi_in = sum[pidfd_pkg::MulAW:1];
         lo_in = {sum[0], lo_ff[pidfd_pkg::MulBW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign prod = {hi_ff, lo_ff};

endmodule

`default_nettype wire

>>> rtl/pidfd_div.sv
// restoring radix-2 divider, one quotient bit per cycle while step is high
// depends on pidfd_pkg
`default_nettype none

module pidfd_div (
   input  wire logic                            clock,
   input  wire pidfd_pkg::unit_ctl_type         ctl,
   input  wire logic [pidfd_pkg::DivNW-1:0]     num,
   input  wire logic [pidfd_pkg::DivDW-1:0]     den,
   output logic [pidfd_pkg::DivNW-1:0]          quot
);

   logic [pidfd_pkg::DivNW-1:0] num_ff, num_in;
   logic [pidfd_pkg::DivDW-1:0] rem_ff, rem_in;
   logic [pidfd_pkg::DivDW-1:0] den_ff, den_in;
   logic [pidfd_pkg::DivDW:0]   shifted;
   logic [pidfd_pkg::DivDW+1:0] trial;
   logic                        fits;

   always_comb begin
      shifted = {rem_ff, num_ff[pidfd_pkg::DivNW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[pidfd_pkg::DivDW+1];
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (ctl.load) begin
         num_in = num;
         rem_in = '0;
         den_in = den;
      end else if (ctl.step) begin
         rem_in = fits ? trial[pidfd_pkg::DivDW-1:0] : shifted[pidfd_pkg::DivDW-1:0];
         num_in = {num_ff[pidfd_pkg::DivNW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = num_ff;

endmodule

`default_nettype wire
